[design/tmm_pkg.sv]
// Shared types and constants for the tiled matrix multiply block.
`default_nettype none

package tmm_pkg;

    // Field widths of the stream words
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 16;
    localparam int TNUM_W   = 12;
    localparam int PROD_W   = 38;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    // Shared divider width (covers the tile number and the tiles-per-side numerator)
    localparam int DIV_W = 12;

    // Saturation bound of a product is +/- 2^36
    localparam int PROD_SAT_SHIFT = 36;

    // Register widths
    localparam int MSIZE_W = 7;
    localparam int TSIZE_W = 4;

    // Register index, taken from paddr[2]
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic REG_TILE_SIZE   = 1'b1;

    // Item kinds carried in s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic clear;
        logic in_valid;
    } mac_ctl_t;

endpackage

`default_nettype wire

[design/tmm_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/tmm_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module tmm_div
    import tmm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CW = $clog2(DIV_W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;

    // trial subtract of the divisor
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[design/tmm_mac.sv]
// Shared multiply-accumulate unit with output saturation.
`default_nettype none

module tmm_mac
    import tmm_pkg::*;
#(
    parameter int ACC_W = 38
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctl_t                 ctl,
    input  wire logic signed [VAL_W-1:0]  a,
    input  wire logic signed [VAL_W-1:0]  b,
    output logic                          busy,
    output logic signed [PROD_W-1:0]      sum
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd1 <<< PROD_SAT_SHIFT);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

    logic                          prod_v_reg;
    logic signed [2*VAL_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctl.in_valid;
        end
    end

    // multiply, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // clamp to +/- 2^36
    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sum = PROD_W'(SAT_HI);
        end
        else if (acc_reg < SAT_LO)
        begin
            sum = PROD_W'(SAT_LO);
        end
        else
        begin
            sum = PROD_W'(acc_reg);
        end
    end

    assign busy = prod_v_reg;

endmodule

`default_nettype wire

[design/tiled_matrix_multiply.sv]
// Top level of the tiled matrix multiply block: sequencer, register port, stream ports.
// Load words are taken in the idle state; s_tready stays high after them.
// A compute word runs two divisions, tiles per side and then tile row and column,
// with the square and range check between them, then works each tile element on
// the shared MAC (one RAM read pair per cycle) and drains it before each result.
// A bad tile number gives its error word after the first division and the range check.
// rst_n clears control and sets matrix_size to 64, tile_size to 8; RAM contents are not cleared.
`default_nettype none

module tiled_matrix_multiply
    import tmm_pkg::*;
#(
    parameter int MAX_DIM  = 64,
    parameter int MAX_TILE = 8
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // stream in
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // row[5:0], col[11:6], value[27:12], tile_number[39:28]
    input  wire logic [FUNC_W-1:0]   s_tuser,  // func[1:0]
    // stream out
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // out_row[5:0], out_col[11:6], product[49:12], zero pad
    output logic                     m_tuser,  // bad_tile[0]
    output logic                     m_tlast,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int DW    = $clog2(MAX_DIM);
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int KW    = $clog2(MAX_TILE + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = (32 + $clog2(MAX_DIM) > PROD_W) ? 32 + $clog2(MAX_DIM) : PROD_W;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_PS_WAIT = 10'b0000000010,
        ST_SQUARE  = 10'b0000000100,
        ST_CHECK   = 10'b0000001000,
        ST_TL_WAIT = 10'b0000010000,
        ST_BOUNDS  = 10'b0000100000,
        ST_MAC     = 10'b0001000000,
        ST_DRAIN   = 10'b0010000000,
        ST_EMIT    = 10'b0100000000,
        ST_BAD     = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic [MSIZE_W-1:0] matrix_size_reg;
    logic [TSIZE_W-1:0] tile_size_reg;

    logic [TNUM_W-1:0] tnum_reg;
    logic [NW-1:0]     per_side_reg;
    logic [2*NW-1:0]   sq_reg;
    logic [DW-1:0]     r0_reg;
    logic [DW-1:0]     c0_reg;
    logic [NW-1:0]     r1_reg;
    logic [NW-1:0]     c1_reg;
    logic [DW-1:0]     r_reg;
    logic [DW-1:0]     c_reg;
    logic [DW-1:0]     p_reg;
    logic              rd_valid_reg;

    logic              m_valid_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [PROD_W-1:0] product_reg;
    logic              last_reg;
    logic              bad_reg;

    logic [POS_W-1:0]  in_row;
    logic [POS_W-1:0]  in_col;
    logic [VAL_W-1:0]  in_value;
    logic [TNUM_W-1:0] in_tnum;

    logic [NW-1:0] n_eff;
    logic [KW-1:0] k_eff;
    logic          s_accept;
    logic          cfg_write;
    logic          out_free;
    logic          elem_last;
    logic          in_range;
    logic [NW:0]   r_end;
    logic [NW:0]   c_end;

    logic                    a_we;
    logic                    b_we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           a_raddr;
    logic [AW-1:0]           b_raddr;
    logic [VAL_W-1:0]        a_rdata;
    logic [VAL_W-1:0]        b_rdata;

    div_req_t                div_req;
    div_rsp_t                div_rsp;
    mac_ctl_t                mac_ctl;
    logic                    mac_busy;
    logic signed [PROD_W-1:0] mac_sum;

    // input word fields
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_value = s_tdata[27:12];
    assign in_tnum  = s_tdata[39:28];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_valid_reg || m_tready;

    // clamped sizes
    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(matrix_size_reg) > MAX_DIM)
        begin
            n_eff = NW'(MAX_DIM);
        end
        else
        begin
            n_eff = NW'(matrix_size_reg);
        end

        if (tile_size_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (32'(tile_size_reg) > MAX_TILE)
        begin
            k_eff = KW'(MAX_TILE);
        end
        else
        begin
            k_eff = KW'(tile_size_reg);
        end
    end

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= MSIZE_W'(64);
            tile_size_reg   <= TSIZE_W'(8);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MATRIX_SIZE: matrix_size_reg <= pwdata[MSIZE_W-1:0];
                REG_TILE_SIZE:   tile_size_reg   <= pwdata[TSIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MATRIX_SIZE: prdata = 32'(matrix_size_reg);
            REG_TILE_SIZE:   prdata = 32'(tile_size_reg);
            default:         prdata = '0;
        endcase
    end

    // element loads
    assign in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign waddr    = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
    assign a_we     = s_accept && (s_tuser == FUNC_LOAD_A) && in_range;
    assign b_we     = s_accept && (s_tuser == FUNC_LOAD_B) && in_range;

    // dot product read addresses: A walks a row, B walks a column
    assign a_raddr = AW'(r_reg) * AW'(MAX_DIM) + AW'(p_reg);
    assign b_raddr = AW'(p_reg) * AW'(MAX_DIM) + AW'(c_reg);

    tmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    tmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // divider requests: tiles per side first, then tile row and column
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(n_eff) + DIV_W'(k_eff) - DIV_W'(1);
        div_req.divisor  = DIV_W'(k_eff);
        if (state_reg == ST_IDLE)
        begin
            div_req.start = s_accept && (s_tuser == FUNC_COMPUTE);
        end
        else if (state_reg == ST_CHECK)
        begin
            div_req.start    = 32'(tnum_reg) < 32'(sq_reg);
            div_req.dividend = tnum_reg;
            div_req.divisor  = DIV_W'(per_side_reg);
        end
    end

    tmm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // tile bounds and last element
    assign r_end     = (NW + 1)'(r0_reg) + (NW + 1)'(k_eff);
    assign c_end     = (NW + 1)'(c0_reg) + (NW + 1)'(k_eff);
    assign elem_last = (NW'(r_reg) + NW'(1) == r1_reg) && (NW'(c_reg) + NW'(1) == c1_reg);

    // MAC control
    assign mac_ctl.in_valid = rd_valid_reg;
    assign mac_ctl.clear    = (state_reg == ST_BOUNDS) ||
                              ((state_reg == ST_EMIT) && out_free && !elem_last);

    tmm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (a_rdata),
        .b     (b_rdata),
        .busy  (mac_busy),
        .sum   (mac_sum)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            tnum_reg     <= '0;
            per_side_reg <= '0;
            sq_reg       <= '0;
            r0_reg       <= '0;
            c0_reg       <= '0;
            r1_reg       <= '0;
            c1_reg       <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            p_reg        <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            product_reg  <= '0;
            last_reg     <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_MAC);
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept && (s_tuser == FUNC_COMPUTE))
                    begin
                        tnum_reg  <= in_tnum;
                        state_reg <= ST_PS_WAIT;
                    end
                end
                ST_PS_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        per_side_reg <= NW'(div_rsp.quotient);
                        state_reg    <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sq_reg    <= (2 * NW)'(per_side_reg) * (2 * NW)'(per_side_reg);
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (32'(tnum_reg) < 32'(sq_reg))
                    begin
                        state_reg <= ST_TL_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_BAD;
                    end
                end
                ST_TL_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        r0_reg    <= DW'(div_rsp.quotient * DIV_W'(k_eff));
                        c0_reg    <= DW'(div_rsp.remainder * DIV_W'(k_eff));
                        state_reg <= ST_BOUNDS;
                    end
                end
                ST_BOUNDS:
                begin
                    r1_reg    <= (r_end < (NW + 1)'(n_eff)) ? NW'(r_end) : n_eff;
                    c1_reg    <= (c_end < (NW + 1)'(n_eff)) ? NW'(c_end) : n_eff;
                    r_reg     <= r0_reg;
                    c_reg     <= c0_reg;
                    p_reg     <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    // one A/B read pair per cycle
                    p_reg <= p_reg + 1'b1;
                    if (NW'(p_reg) + NW'(1) == n_eff)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_valid_reg && !mac_busy)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        out_row_reg <= POS_W'(r_reg);
                        out_col_reg <= POS_W'(c_reg);
                        product_reg <= mac_sum;
                        last_reg    <= elem_last;
                        bad_reg     <= 1'b0;
                        if (elem_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            // row-major walk over the clipped tile
                            if (NW'(c_reg) + NW'(1) == c1_reg)
                            begin
                                c_reg <= c0_reg;
                                r_reg <= r_reg + 1'b1;
                            end
                            else
                            begin
                                c_reg <= c_reg + 1'b1;
                            end
                            p_reg     <= '0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_BAD:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                        product_reg <= '0;
                        last_reg    <= 1'b0;
                        bad_reg     <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - PROD_W - 2 * POS_W){1'b0}}, product_reg,
                       out_col_reg, out_row_reg};
    assign m_tuser  = bad_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[design/tmm_checker.sv]
// Port-level assertions for the tiled matrix multiply block, bound to the top level.
`default_nettype none

module tmm_checker
    import tmm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic [FUNC_W-1:0]   s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser,
    input wire logic                m_tlast,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic [2:0]          paddr,
    input wire logic [31:0]         pwdata,
    input wire logic [31:0]         prdata,
    input wire logic                pready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result word changed");

    // an error word carries no element and no last mark
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("error word with payload");

    // a compute word keeps the input closed while the tile is worked
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_COMPUTE) |=> !s_tready)
        else $error("input open right after compute word");

    // a matrix_size write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_MATRIX_SIZE)) ##1
        (paddr[2] == REG_MATRIX_SIZE) && !pwrite
        |-> prdata[MSIZE_W-1:0] == $past(pwdata[MSIZE_W-1:0]))
        else $error("matrix_size readback mismatch");

endmodule

bind tiled_matrix_multiply tmm_checker u_tmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

`default_nettype wire

[bench/tiled_matrix_multiply_test.sv]
// Self-checking stream testbench for the tiled matrix multiply block.
`timescale 1ns / 1ps

module tiled_matrix_multiply_test;
    import tmm_pkg::*;

    localparam int DIM      = 64;
    localparam int TILE_MAX = 8;

    // func code with no meaning, the block drops the word
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // one product word as it leaves the block
    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [PROD_W-1:0] product;
        logic              last;
        logic              bad;
    } tile_word_t;

    typedef enum logic [1:0] {
        ROW_CFG,    // new sizes, written once the block is idle
        ROW_WORD,   // stream word, outcome from the predictor
        ROW_TYPED   // stream word, outcome spelled out here
    } row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic [TNUM_W-1:0] tnum;
        tile_word_t        want;
        logic [MSIZE_W-1:0] msize;
        logic [TSIZE_W-1:0] tsize;
    } step_t;

    localparam tile_word_t NO_WORD  = '0;
    localparam tile_word_t BAD_WORD = '{0, 0, 0, 1'b0, 1'b1};
    localparam tile_word_t MAX_SQ   = '{0, 0, 38'sd1073741824, 1'b1, 1'b0};
    localparam tile_word_t MIX_SQ   = '{0, 0, -38'sd1073709056, 1'b1, 1'b0};

    // directed walk: reset sizes, extremes, clamped registers, clipped tiles, bad tiles
    localparam int PLAN_LEN = 25;
    localparam step_t PLAN [PLAN_LEN] = '{
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 64, BAD_WORD, 0, 0},
        '{ROW_WORD,  FUNC_COMPUTE, 0, 0, 16'h0000, 63, NO_WORD, 0, 0},
        '{ROW_WORD,  FUNC_COMPUTE, 0, 0, 16'h0000, 0, NO_WORD, 0, 0},
        '{ROW_WORD,  FUNC_UNUSED, 63, 63, 16'hFFFF, 4095, NO_WORD, 0, 0},
        '{ROW_CFG,   FUNC_LOAD_A, 0, 0, 16'h0000, 0, NO_WORD, 1, 1},
        '{ROW_WORD,  FUNC_LOAD_A, 0, 0, 16'h8000, 0, NO_WORD, 0, 0},
        '{ROW_WORD,  FUNC_LOAD_B, 0, 0, 16'h8000, 0, NO_WORD, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 0, MAX_SQ, 0, 0},
        '{ROW_WORD,  FUNC_LOAD_A, 0, 0, 16'h7FFF, 0, NO_WORD, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 0, MIX_SQ, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 1, BAD_WORD, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 4095, BAD_WORD, 0, 0},
        '{ROW_WORD,  FUNC_LOAD_B, 63, 63, 16'h7FFF, 0, NO_WORD, 0, 0},
        '{ROW_WORD,  FUNC_LOAD_A, 63, 63, 16'h8000, 0, NO_WORD, 0, 0},
        '{ROW_CFG,   FUNC_LOAD_A, 0, 0, 16'h0000, 0, NO_WORD, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 0, MIX_SQ, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 1, BAD_WORD, 0, 0},
        '{ROW_CFG,   FUNC_LOAD_A, 0, 0, 16'h0000, 0, NO_WORD, 127, 15},
        '{ROW_WORD,  FUNC_COMPUTE, 0, 0, 16'h0000, 63, NO_WORD, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 64, BAD_WORD, 0, 0},
        '{ROW_CFG,   FUNC_LOAD_A, 0, 0, 16'h0000, 0, NO_WORD, 5, 2},
        '{ROW_WORD,  FUNC_COMPUTE, 0, 0, 16'h0000, 8, NO_WORD, 0, 0},
        '{ROW_WORD,  FUNC_COMPUTE, 0, 0, 16'h0000, 2, NO_WORD, 0, 0},
        '{ROW_TYPED, FUNC_COMPUTE, 0, 0, 16'h0000, 9, BAD_WORD, 0, 0},
        '{ROW_WORD,  FUNC_UNUSED, 0, 0, 16'h0000, 0, NO_WORD, 0, 0}
    };

    // sizes of the random phases; the last phases draw their own
    localparam int PHASE_DIM  [8] = '{1, 2, 64, 9, 13, 127, 20, 0};
    localparam int PHASE_TILE [8] = '{1, 8, 8, 2, 5, 0, 3, 15};
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 45;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // row[5:0], col[11:6], value[27:12], tile_number[39:28]
    logic [FUNC_W-1:0]   s_tuser;   // func[1:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // out_row[5:0], out_col[11:6], product[49:12], zero pad
    logic                m_tuser;   // bad_tile[0]
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // shadow copy of the block: operand matrices and size registers
    logic signed [VAL_W-1:0] mat_a [DIM][DIM];
    logic signed [VAL_W-1:0] mat_b [DIM][DIM];
    logic [MSIZE_W-1:0]      msize_reg = 7'd64;
    logic [TSIZE_W-1:0]      tsize_reg = 4'd8;

    tile_word_t awaited_words [$];
    tile_word_t got_word;
    tile_word_t want_word;
    int         errors      = 0;
    int         words_taken = 0;
    int         tx_calm     = 0;

    tiled_matrix_multiply #(
        .MAX_DIM  (DIM),
        .MAX_TILE (TILE_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sizes as the block uses them, clamped into range
    function automatic int eff_dim();
        if (msize_reg == 0)
            return 1;
        if (msize_reg > DIM)
            return DIM;
        return int'(msize_reg);
    endfunction

    function automatic int eff_tile();
        if (tsize_reg == 0)
            return 1;
        if (tsize_reg > TILE_MAX)
            return TILE_MAX;
        return int'(tsize_reg);
    endfunction

    // queue the words one compute word should produce
    function automatic void tile_products(input logic [TNUM_W-1:0] tnum);
        int         n;
        int         k;
        int         per;
        int         r0;
        int         c0;
        int         r1;
        int         c1;
        longint     acc;
        tile_word_t w;
        n   = eff_dim();
        k   = eff_tile();
        per = (n + k - 1) / k;
        if (int'(tnum) >= per * per)
        begin
            awaited_words.push_back(BAD_WORD);
            return;
        end
        r0 = (int'(tnum) / per) * k;
        c0 = (int'(tnum) % per) * k;
        r1 = (r0 + k < n) ? r0 + k : n;
        c1 = (c0 + k < n) ? c0 + k : n;
        for (int r = r0; r < r1; r++)
        begin
            for (int c = c0; c < c1; c++)
            begin
                acc = 0;
                for (int p = 0; p < n; p++)
                    acc += longint'(mat_a[r][p]) * longint'(mat_b[p][c]);
                // saturation bound, only hit beyond 64 terms
                if (acc > (64'sd1 <<< PROD_SAT_SHIFT))
                    acc = 64'sd1 <<< PROD_SAT_SHIFT;
                if (acc < -(64'sd1 <<< PROD_SAT_SHIFT))
                    acc = -(64'sd1 <<< PROD_SAT_SHIFT);
                w.row     = r[POS_W-1:0];
                w.col     = c[POS_W-1:0];
                w.product = acc[PROD_W-1:0];
                w.last    = (r == r1 - 1) && (c == c1 - 1);
                w.bad     = 1'b0;
                awaited_words.push_back(w);
            end
        end
    endfunction

    // idle cycles before the next word, with runs of back-to-back words
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word, update the shadow state once it is taken
    task automatic issue_word(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col, input logic [VAL_W-1:0] value,
                              input logic [TNUM_W-1:0] tnum, input bit typed,
                              input tile_word_t want);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tnum, value, col, row};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (func)
            FUNC_LOAD_A:  mat_a[row][col] = value;
            FUNC_LOAD_B:  mat_b[row][col] = value;
            FUNC_COMPUTE:
            begin
                if (typed)
                    awaited_words.push_back(want);
                else
                    tile_products(tnum);
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    // stop offering, let every awaited word drain, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // one register transfer: setup phase, access phase, then the bus is released
    task automatic reg_access(input logic sel, input bit wr, input logic [31:0] v,
                              input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (wr)
        begin
            if (sel == REG_MATRIX_SIZE)
                msize_reg = v[MSIZE_W-1:0];
            else
                tsize_reg = v[TSIZE_W-1:0];
        end
        else if (prdata !== want)
        begin
            $error("prdata expected %0d got %0d", want, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // write a register and read it back
    task automatic set_reg(input logic sel, input logic [31:0] v);
        reg_access(sel, 1'b1, v, 32'd0);
        reg_access(sel, 1'b0, 32'd0,
                   (sel == REG_MATRIX_SIZE) ? 32'(v[MSIZE_W-1:0]) : 32'(v[TSIZE_W-1:0]));
    endtask

    // compare every taken word with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            words_taken++;
            got_word = '{m_tdata[5:0], m_tdata[11:6], m_tdata[49:12], m_tlast, m_tuser};
            if (awaited_words.size() == 0)
            begin
                $error("word with nothing awaited: row %0d col %0d", got_word.row, got_word.col);
                errors++;
            end
            else
            begin
                want_word = awaited_words.pop_front();
                if (got_word.row !== want_word.row)
                begin
                    $error("out_row expected %0d got %0d", want_word.row, got_word.row);
                    errors++;
                end
                if (got_word.col !== want_word.col)
                begin
                    $error("out_col expected %0d got %0d", want_word.col, got_word.col);
                    errors++;
                end
                if (got_word.product !== want_word.product)
                begin
                    $error("product expected %0d got %0d",
                           $signed(want_word.product), $signed(got_word.product));
                    errors++;
                end
                if (got_word.last !== want_word.last)
                begin
                    $error("last expected %0d got %0d", want_word.last, got_word.last);
                    errors++;
                end
                if (got_word.bad !== want_word.bad)
                begin
                    $error("bad_tile expected %0d got %0d", want_word.bad, got_word.bad);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off once traffic is flowing
    initial
    begin
        int gap;
        bit held;
        int calm;
        held     = 1'b0;
        calm     = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!held && words_taken >= 400)
            begin
                gap  = 600;
                held = 1'b1;
            end
            else
                gap = draw_gap(calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial
    begin
        int                 phase;
        int                 n;
        int                 k;
        int                 tiles;
        int                 pick;
        logic [FUNC_W-1:0]  func;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VAL_W-1:0]   value;
        logic [TNUM_W-1:0]  tnum;
        logic [MSIZE_W-1:0] ms;
        logic [TSIZE_W-1:0] ts;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sizes after reset
        reg_access(REG_MATRIX_SIZE, 1'b0, 32'd0, 32'd64);
        reg_access(REG_TILE_SIZE, 1'b0, 32'd0, 32'd8);

        // RAM is not cleared by reset: write every entry of both matrices first
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                issue_word(FUNC_LOAD_A, r[POS_W-1:0], c[POS_W-1:0], draw_value(),
                           12'($urandom), 1'b0, NO_WORD);
                issue_word(FUNC_LOAD_B, r[POS_W-1:0], c[POS_W-1:0], draw_value(),
                           12'($urandom), 1'b0, NO_WORD);
            end
        end

        // directed part
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                settle();
                set_reg(REG_MATRIX_SIZE, 32'(PLAN[i].msize));
                set_reg(REG_TILE_SIZE, 32'(PLAN[i].tsize));
            end
            else
                issue_word(PLAN[i].func, PLAN[i].row, PLAN[i].col, PLAN[i].value,
                           PLAN[i].tnum, PLAN[i].kind == ROW_TYPED, PLAN[i].want);
        end

        // random phases, each under its own sizes
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 8)
            begin
                ms = PHASE_DIM[phase][MSIZE_W-1:0];
                ts = PHASE_TILE[phase][TSIZE_W-1:0];
            end
            else
            begin
                ms = 7'($urandom_range(1, 24));
                ts = 4'($urandom_range(0, 15));
            end
            settle();
            set_reg(REG_MATRIX_SIZE, 32'(ms));
            set_reg(REG_TILE_SIZE, 32'(ts));
            n     = eff_dim();
            k     = eff_tile();
            tiles = ((n + k - 1) / k) * ((n + k - 1) / k);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                pick  = $urandom_range(0, 99);
                row   = 6'($urandom);
                col   = 6'($urandom);
                value = draw_value();
                tnum  = 12'($urandom);
                if (pick < 58)
                begin
                    func = pick[0] ? FUNC_LOAD_B : FUNC_LOAD_A;
                    // mostly inside the active square so the loads matter
                    if ($urandom_range(0, 3) != 0)
                    begin
                        row = 6'($urandom_range(0, n - 1));
                        col = 6'($urandom_range(0, n - 1));
                    end
                end
                else if (pick < 90)
                begin
                    func = FUNC_COMPUTE;
                    tnum = 12'($urandom_range(0, tiles - 1));
                end
                else if (pick < 96 && tiles <= 4095)
                begin
                    func = FUNC_COMPUTE;
                    tnum = 12'($urandom_range(tiles, 4095));
                end
                else
                    func = FUNC_UNUSED;
                issue_word(func, row, col, value, tnum, 1'b0, NO_WORD);
            end
        end

        settle();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[tiled_matrix_multiply.f]
design/tmm_pkg.sv
design/tmm_ram.sv
design/tmm_div.sv
design/tmm_mac.sv
design/tiled_matrix_multiply.sv
design/tmm_checker.sv
bench/tiled_matrix_multiply_test.sv
